// ===== hdl/assert_macros.svh =====
// Assertion macros used by the allocator engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dba_pkg.sv =====
// Shared types and codes of the disk block allocator.
package dba_pkg;

  localparam int MAX_RESULTS = 64;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [1:0] MODE_CONTIG  = 2'd0;
  localparam logic [1:0] MODE_LINKED  = 2'd1;
  localparam logic [1:0] MODE_INDEXED = 2'd2;

  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_SET    = 2'd0;
  localparam cmd_kind_t CMD_CONTIG = 2'd1;
  localparam cmd_kind_t CMD_LIST   = 2'd2;
  localparam cmd_kind_t CMD_NOSPC  = 2'd3;

  // cnt: run length for contiguous, total result count for list allocation
  typedef struct packed {
    cmd_kind_t  kind;
    logic [5:0] blk;
    logic       used;
    logic [6:0] cnt;
    logic       idx_mode;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [5:0] block_number;
    logic       is_index_block;
    logic       last;
  } res_t;

endpackage

// ===== hdl/dba_ram.sv =====
// Generic simple dual-port RAM with registered read.
module dba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dba_fifo.sv =====
// Two-entry register queue.
module dba_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/dba_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
module dba_front
  import dba_pkg::*;
#(
  parameter int BLOCK_COUNT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_opcode,
  input  logic [5:0] in_block_index,
  input  logic       in_block_used,
  input  logic [6:0] in_file_size,
  output logic       in_full,
  input  logic [1:0] alloc_mode,
  input  logic       hold,
  input  logic       cmd_pop,
  output cmd_t       cmd_data,
  output logic       cmd_empty
);

  logic                   accept;
  logic                   q_full;
  logic                   q_push;
  logic                   in_range;
  logic                   idx_mode;
  logic [7:0]             total_w;
  cmd_t                   cmd_w;
  logic [$bits(cmd_t)-1:0] q_rdata;

  assign in_full  = q_full || hold;
  assign accept   = in_push && !in_full;
  assign in_range = (32'(in_block_index) < BLOCK_COUNT);
  assign idx_mode = (alloc_mode == MODE_INDEXED);
  assign total_w  = {1'b0, in_file_size} + {7'd0, idx_mode};

  always_comb begin
    cmd_w.blk      = in_block_index;
    cmd_w.used     = in_block_used;
    cmd_w.cnt      = total_w[6:0];
    cmd_w.idx_mode = idx_mode;
    cmd_w.kind     = CMD_NOSPC;
    case (in_opcode)
      OP_SET: cmd_w.kind = CMD_SET;
      OP_ALLOC: begin
        if (in_file_size == 7'd0 ||
            !(alloc_mode inside {MODE_CONTIG, MODE_LINKED, MODE_INDEXED}) ||
            total_w > 8'(MAX_RESULTS)) begin
          cmd_w.kind = CMD_NOSPC;
        end else if (alloc_mode == MODE_CONTIG) begin
          cmd_w.kind = CMD_CONTIG;
        end else begin
          cmd_w.kind = CMD_LIST;
        end
      end
      default: cmd_w.kind = CMD_NOSPC;
    endcase
  end

  // drop set beats aimed past the end of the disk
  assign q_push = accept && !(in_opcode == OP_SET && !in_range);

  dba_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (cmd_w),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (cmd_empty)
  );

  assign cmd_data = cmd_t'(q_rdata);

endmodule

// ===== hdl/dba_engine.sv =====
// Back end: bitmap RAM, clear sweep, scan and allocation sequencer.
`include "assert_macros.svh"

module dba_engine
  import dba_pkg::*;
#(
  parameter int BLOCK_COUNT = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  input  cmd_t cmd_data,
  output logic cmd_pop,
  input  logic res_ready,
  output logic res_push,
  output res_t res_data,
  output logic clearing
);

  localparam int AW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int CW = $clog2(BLOCK_COUNT + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(BLOCK_COUNT - 1);
  localparam logic [CW-1:0] BC       = CW'(BLOCK_COUNT);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_ALLOC = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_NOSPC = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          q_vld_r, q_vld_nxt;
  logic [AW-1:0] q_idx_r, q_idx_nxt;
  logic          q_last_r, q_last_nxt;
  cmd_t          cmd_r, cmd_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  logic          d_free;
  logic [6:0]    cnt_inc;
  logic          issue;
  logic          found;
  logic          is_last;

  assign d_free   = !ram_rdata;
  assign cnt_inc  = cnt_r + 7'd1;
  assign issue    = (idx_r < BC);
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    q_vld_nxt  = q_vld_r;
    q_idx_nxt  = q_idx_r;
    q_last_nxt = q_last_r;
    cmd_nxt    = cmd_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r[AW-1:0];
    ram_wdata  = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    res_push   = 1'b0;
    res_data   = '0;
    cmd_pop    = 1'b0;
    found      = q_vld_r && d_free && (cnt_inc == cmd_r.cnt);
    is_last    = (cnt_inc == cmd_r.cnt);

    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_data;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          q_vld_nxt = 1'b0;
          case (cmd_data.kind)
            CMD_SET: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cmd_data.blk);
              ram_wdata = cmd_data.used;
            end
            CMD_CONTIG, CMD_LIST: state_nxt = ST_SCAN;
            default: state_nxt = ST_NOSPC;
          endcase
        end
      end

      // first pass: look for a run, or count free blocks; nothing changes
      ST_SCAN: begin
        if (q_vld_r) begin
          if (d_free) begin
            cnt_nxt = cnt_inc;
          end else if (cmd_r.kind == CMD_CONTIG) begin
            cnt_nxt = '0;
          end
        end
        if (found) begin
          q_vld_nxt = 1'b0;
          cnt_nxt   = '0;
          if (cmd_r.kind == CMD_CONTIG) begin
            state_nxt = ST_RUN;
            idx_nxt   = CW'(q_idx_r) - CW'(cmd_r.cnt) + CW'(1);
          end else begin
            state_nxt = ST_ALLOC;
            idx_nxt   = '0;
          end
        end else if (q_vld_r && q_last_r) begin
          q_vld_nxt = 1'b0;
          state_nxt = ST_NOSPC;
        end else begin
          ram_re     = issue;
          q_vld_nxt  = issue;
          q_idx_nxt  = idx_r[AW-1:0];
          q_last_nxt = (idx_r == LAST_IDX);
          if (issue) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end

      // second pass: claim the lowest free blocks, one per result
      ST_ALLOC: begin
        if (q_vld_r && d_free) begin
          if (res_ready) begin
            ram_we                  = 1'b1;
            ram_waddr               = q_idx_r;
            ram_wdata               = 1'b1;
            res_push                = 1'b1;
            res_data.status         = 1'b0;
            res_data.block_number   = 6'(q_idx_r);
            res_data.is_index_block = cmd_r.idx_mode && (cnt_r == 7'd0);
            res_data.last           = is_last;
            cnt_nxt                 = cnt_inc;
            if (is_last) begin
              state_nxt = ST_IDLE;
              q_vld_nxt = 1'b0;
            end else begin
              ram_re    = issue;
              q_vld_nxt = issue;
              q_idx_nxt = idx_r[AW-1:0];
              if (issue) begin
                idx_nxt = idx_r + CW'(1);
              end
            end
          end
          // hold the read data while the result queue is full
        end else begin
          ram_re    = issue;
          q_vld_nxt = issue;
          q_idx_nxt = idx_r[AW-1:0];
          if (issue) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end

      ST_RUN: begin
        if (res_ready) begin
          ram_we                  = 1'b1;
          ram_wdata               = 1'b1;
          res_push                = 1'b1;
          res_data.status         = 1'b0;
          res_data.block_number   = 6'(idx_r[AW-1:0]);
          res_data.is_index_block = 1'b0;
          res_data.last           = is_last;
          cnt_nxt                 = cnt_inc;
          idx_nxt                 = idx_r + CW'(1);
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_NOSPC: begin
        if (res_ready) begin
          res_push                = 1'b1;
          res_data.status         = 1'b1;
          res_data.block_number   = 6'd0;
          res_data.is_index_block = 1'b0;
          res_data.last           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      cnt_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      q_vld_r <= q_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_idx_r  <= q_idx_nxt;
    q_last_r <= q_last_nxt;
    cmd_r    <= cmd_nxt;
  end

  dba_ram #(
    .WIDTH (1),
    .DEPTH (BLOCK_COUNT),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `ASSERT_IMPL(a_alloc_bound, state_r == ST_ALLOC, cnt_r < cmd_r.cnt,
               "allocation passed its result count")
  `ASSERT_IMPL(a_run_range, state_r == ST_RUN, idx_r < BC,
               "contiguous run ran past the disk")
  `ASSERT_IMPL(a_clear_done, $fell(clearing), $past(idx_r) == LAST_IDX,
               "clear sweep ended early")
  `ASSERT_NEXT(a_stall_hold,
               state_r == ST_ALLOC && q_vld_r && d_free && !res_ready,
               q_vld_r && $stable(q_idx_r),
               "stalled block lost")

endmodule

// ===== hdl/disk_block_allocator_unit.sv =====
// Disk block allocator: bitmap of BLOCK_COUNT blocks with contiguous, linked
// and indexed allocation. After reset the bitmap is swept clear, one block per
// cycle, with in_full high. A set-block beat is written into the bitmap as the
// back end takes it from the command queue. An allocate beat is taken from the
// queue, then makes a read pass over the bitmap RAM (one block per cycle) to
// check that the request fits, then a second pass that writes and emits up
// to one block per cycle while the result queue has room; linked and indexed
// mode rescan from block 0 for this pass. A request that cannot be met gives
// one no-space result and leaves the bitmap as it was. A two-entry command
// queue and a two-entry result queue let input and output stall independently.
module disk_block_allocator_unit
  import dba_pkg::*;
#(
  parameter int BLOCK_COUNT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_opcode,
  input  logic [5:0] in_block_index,
  input  logic       in_block_used,
  input  logic [6:0] in_file_size,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_status,
  output logic [5:0] out_block_number,
  output logic       out_is_index_block,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_alloc_mode
);

  logic [1:0]              alloc_mode_r, alloc_mode_nxt;
  logic                    clearing;
  logic                    cmd_pop;
  logic                    cmd_empty;
  cmd_t                    cmd_data;
  logic                    res_push;
  logic                    res_full;
  res_t                    res_data;
  logic [$bits(res_t)-1:0] out_bits;
  res_t                    out_res;

  assign cfg_ready      = 1'b1;
  assign alloc_mode_nxt = (cfg_valid && cfg_ready) ? cfg_alloc_mode : alloc_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_mode_r <= MODE_CONTIG;
    end else begin
      alloc_mode_r <= alloc_mode_nxt;
    end
  end

  dba_front #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_opcode      (in_opcode),
    .in_block_index (in_block_index),
    .in_block_used  (in_block_used),
    .in_file_size   (in_file_size),
    .in_full        (in_full),
    .alloc_mode     (alloc_mode_r),
    .hold           (clearing),
    .cmd_pop        (cmd_pop),
    .cmd_data       (cmd_data),
    .cmd_empty      (cmd_empty)
  );

  dba_engine #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_ready (!res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .clearing  (clearing)
  );

  dba_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_res            = res_t'(out_bits);
  assign out_status         = out_res.status;
  assign out_block_number   = out_res.block_number;
  assign out_is_index_block = out_res.is_index_block;
  assign out_last           = out_res.last;

endmodule

// ===== sim/disk_block_allocator_unit_checker.sv =====
// Checker for the disk block allocator: shadow bitmap, expected grants and compare.
module disk_block_allocator_unit_checker
  import dba_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic       in_opcode,
  input  logic [5:0] in_block_index,
  input  logic       in_block_used,
  input  logic [6:0] in_file_size,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic       out_status,
  input  logic [5:0] out_block_number,
  input  logic       out_is_index_block,
  input  logic       out_last,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_alloc_mode,
  output int         grant_errors,
  output int         grants_outstanding
);

  localparam int   DISK_BLOCKS  = 64;
  localparam int   REPORT_LIMIT = 10;
  localparam logic ST_GRANTED   = 1'b0;
  localparam logic ST_NO_SPACE  = 1'b1;

  logic [DISK_BLOCKS-1:0] block_map;
  logic [1:0]             mode_reg;
  res_t                   due_grants[$];

  function automatic void expect_grant(input logic [5:0] blk, input logic idx,
                                       input logic fin);
    res_t g;
    g.status         = ST_GRANTED;
    g.block_number   = blk;
    g.is_index_block = idx;
    g.last           = fin;
    due_grants.insert(due_grants.size(), g);
  endfunction

  function automatic void expect_no_space();
    res_t g;
    g.status         = ST_NO_SPACE;
    g.block_number   = '0;
    g.is_index_block = 1'b0;
    g.last           = 1'b1;
    due_grants.insert(due_grants.size(), g);
  endfunction

  function automatic void allocate_blocks(input logic [6:0] size);
    int need;
    int start;
    int run;
    int taken;
    need = int'(size) + ((mode_reg == MODE_INDEXED) ? 1 : 0);
    if (size == 7'd0 || need > MAX_RESULTS ||
        (mode_reg != MODE_CONTIG && mode_reg != MODE_LINKED &&
         mode_reg != MODE_INDEXED)) begin
      expect_no_space();
      return;
    end
    if (mode_reg == MODE_CONTIG) begin
      start = -1;
      run = 0;
      // first fit: lowest start of a free run of the requested length
      for (int b = 0; b < DISK_BLOCKS && start < 0; b++) begin
        if (block_map[b]) begin
          run = 0;
        end else begin
          run++;
          if (run == need) start = b - need + 1;
        end
      end
      if (start < 0) begin
        expect_no_space();
        return;
      end
      for (int b = start; b < start + need; b++) begin
        block_map[b] = 1'b1;
        expect_grant(6'(b), 1'b0, b == start + need - 1);
      end
      return;
    end
    // linked and indexed: lowest free blocks, index block first
    if ($countones(~block_map) < need) begin
      expect_no_space();
      return;
    end
    taken = 0;
    for (int b = 0; b < DISK_BLOCKS && taken < need; b++) begin
      if (!block_map[b]) begin
        block_map[b] = 1'b1;
        expect_grant(6'(b), mode_reg == MODE_INDEXED && taken == 0, taken + 1 == need);
        taken++;
      end
    end
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      block_map = '0;
      mode_reg = MODE_CONTIG;
      due_grants.delete();
      grant_errors = 0;
      grants_outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_reg = cfg_alloc_mode;
      if (out_pop && !out_empty) begin
        got.status         = out_status;
        got.block_number   = out_block_number;
        got.is_index_block = out_is_index_block;
        got.last           = out_last;
        if (due_grants.size() == 0) begin
          grant_errors++;
          if (grant_errors <= REPORT_LIMIT)
            $display("unexpected grant beat: status %0d block %0d index %0d last %0d",
                     got.status, got.block_number, got.is_index_block, got.last);
        end else begin
          want = due_grants.pop_front();
          if (got.status !== want.status || got.block_number !== want.block_number ||
              got.is_index_block !== want.is_index_block || got.last !== want.last) begin
            grant_errors++;
            if (grant_errors <= REPORT_LIMIT)
              $display("grant mismatch (status/block/index/last): expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                       want.status, want.block_number, want.is_index_block, want.last,
                       got.status, got.block_number, got.is_index_block, got.last);
          end
        end
      end
      if (in_push && !in_full) begin
        if (in_opcode == OP_SET) block_map[in_block_index] = in_block_used;
        else allocate_blocks(in_file_size);
      end
      grants_outstanding = due_grants.size();
    end
  end

endmodule

// ===== sim/disk_block_allocator_unit_tb.sv =====
// Testbench top for the disk block allocator: clock, reset, stimulus and verdict.
module disk_block_allocator_unit_tb;
  import dba_pkg::*;

  localparam logic [1:0] MODE_UNDEFINED = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 160;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 58;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_opcode = OP_SET;
  logic [5:0] in_block_index = '0;
  logic       in_block_used = 1'b0;
  logic [6:0] in_file_size = '0;
  logic       in_full;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic       out_status;
  logic [5:0] out_block_number;
  logic       out_is_index_block;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_alloc_mode = MODE_CONTIG;

  int   grant_errors;
  int   grants_outstanding;
  int   tx_idle_pct = 32;
  int   rx_idle_pct = 77;
  int   quiet_cycles = 0;
  logic stall_request = 1'b0;

  disk_block_allocator_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_opcode          (in_opcode),
    .in_block_index     (in_block_index),
    .in_block_used      (in_block_used),
    .in_file_size       (in_file_size),
    .in_full            (in_full),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_block_number   (out_block_number),
    .out_is_index_block (out_is_index_block),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_alloc_mode     (cfg_alloc_mode)
  );

  disk_block_allocator_unit_checker grant_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_opcode          (in_opcode),
    .in_block_index     (in_block_index),
    .in_block_used      (in_block_used),
    .in_file_size       (in_file_size),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_block_number   (out_block_number),
    .out_is_index_block (out_is_index_block),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_alloc_mode     (cfg_alloc_mode),
    .grant_errors       (grant_errors),
    .grants_outstanding (grants_outstanding)
  );

  always #10 clk = ~clk;

  // end the run when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random pops, plus one long hold-off on request
  initial begin
    int   hold_left;
    logic stall_served;
    hold_left = 0;
    stall_served = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !stall_served) begin
        hold_left = HOLD_CYCLES;
        stall_served = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // all tasks below start and end at a falling edge
  task automatic offer(input logic op, input logic [5:0] blk, input logic used,
                       input logic [6:0] size);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push        <= 1'b1;
    in_opcode      <= op;
    in_block_index <= blk;
    in_block_used  <= used;
    in_file_size   <= size;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_block(input logic [5:0] blk, input logic used);
    offer(OP_SET, blk, used, 7'($urandom));
  endtask

  task automatic allocate(input logic [6:0] size);
    offer(OP_ALLOC, 6'($urandom), 1'($urandom), size);
  endtask

  task automatic reclaim(input logic [5:0] first, input int span);
    for (int k = 0; k < span; k++) set_block(6'(first + k), 1'b0);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    cfg_alloc_mode <= mode;
    cfg_valid      <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every expected grant, then let trailing set beats retire
  task automatic drain();
    in_push <= 1'b0;
    while (grants_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [6:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 7'($urandom_range(1, 4));
    else if (sel < 85) return 7'($urandom_range(5, 16));
    else if (sel < 93) return 7'($urandom_range(17, 64));
    else if (sel < 96) return 7'd0;
    else return 7'($urandom_range(65, 127));
  endfunction

  task automatic run_phase(input logic [1:0] mode, input int tx_pct, input int rx_pct,
                           input logic hold_receiver);
    int sent;
    int sel;
    int span;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    drain();
    write_mode(mode);
    if (hold_receiver) stall_request = 1'b1;
    // open up room first so that allocations get past the no-space path
    span = $urandom_range(16, 40);
    reclaim(6'($urandom), span);
    sent = span;
    while (sent < PHASE_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        set_block(6'($urandom), $urandom_range(0, 99) < 35);
        sent++;
      end else if (sel < 95) begin
        allocate(pick_size());
        sent++;
      end else begin
        span = $urandom_range(4, 12);
        reclaim(6'($urandom), span);
        sent += span;
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    write_mode(MODE_CONTIG);

    // contiguous: zero size, full disk, no run, oversize request
    allocate(7'd0);
    allocate(7'd64);
    allocate(7'd1);
    set_block(6'd0, 1'b0);
    set_block(6'd63, 1'b0);
    set_block(6'd32, 1'b0);
    allocate(7'd2);
    allocate(7'd1);
    allocate(7'd127);
    set_block(6'd33, 1'b0);
    allocate(7'd2);
    drain();

    // linked: scattered free blocks, then a full disk
    write_mode(MODE_LINKED);
    set_block(6'd5, 1'b0);
    set_block(6'd40, 1'b0);
    allocate(7'd3);
    allocate(7'd1);
    drain();

    // indexed: a size that needs one result too many, then index plus data
    write_mode(MODE_INDEXED);
    allocate(7'd64);
    set_block(6'd1, 1'b0);
    set_block(6'd2, 1'b0);
    set_block(6'd5, 1'b0);
    allocate(7'd2);
    allocate(7'd1);
    drain();

    // undefined mode refuses every allocation request
    write_mode(MODE_UNDEFINED);
    set_block(6'd62, 1'b0);
    allocate(7'd1);
    allocate(7'd127);

    run_phase(MODE_CONTIG, 32, 77, 1'b0);
    run_phase(MODE_LINKED, 77, 32, 1'b0);
    run_phase(MODE_INDEXED, 0, 0, 1'b1);
    drain();

    if (grant_errors == 0 && grants_outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
